### design/assert_macros.svh
// Assertion macros for the RTL files; only the deque top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif
`endif

### design/bdq_pkg.sv
// Shared types and constants for the bounded deque.
`default_nettype none

package bdq_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;
    localparam int CMD_W              = 2;
    localparam int STATUS_W           = 2;
    localparam int VALUE_W            = 32;
    localparam int COUNT_W            = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_PREPEND = 2'd0,
        CMD_APPEND  = 2'd1,
        CMD_DEQUEUE = 2'd2,
        CMD_DELETE  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE  = 3'b001,
        FSM_MATCH = 3'b010,
        FSM_EXEC  = 3'b100
    } fsm_t;

    typedef struct packed {
        logic compare;
        logic apply;
        cmd_t cmd;
    } bdq_ctl_t;

endpackage

`default_nettype wire

### design/bdq_cell.sv
// One deque cell: a stored word, its valid bit and its match flag.
`default_nettype none

module bdq_cell #(
    parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire bdq_pkg::bdq_ctl_t     ctl,
    input  wire logic [DATA_WIDTH-1:0] value,
    input  wire logic                  prev_valid,
    input  wire logic [DATA_WIDTH-1:0] prev_data,
    input  wire logic                  prev_hit,
    input  wire logic                  next_valid,
    input  wire logic [DATA_WIDTH-1:0] next_data,
    output logic                       valid,
    output logic [DATA_WIDTH-1:0]      data,
    output logic                       hit
);
    import bdq_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  match_reg;
    logic                  match_next;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        match_next = match_reg;
        if (ctl.compare)
        begin
            match_next = valid_reg && (data_reg == value);
        end
        if (ctl.apply)
        begin
            unique case (ctl.cmd)
                CMD_PREPEND:
                begin
                    valid_next = prev_valid;
                    data_next  = prev_data;
                end
                CMD_APPEND:
                begin
                    if (!valid_reg && prev_valid)
                    begin
                        valid_next = 1'b1;
                        data_next  = value;
                    end
                end
                CMD_DEQUEUE:
                begin
                    valid_next = next_valid;
                    data_next  = next_data;
                end
                CMD_DELETE:
                begin
                    if (prev_hit || match_reg)
                    begin
                        valid_next = next_valid;
                        data_next  = next_data;
                    end
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;
    assign hit   = prev_hit || match_reg;

endmodule

`default_nettype wire

### design/bounded_deque_with_delete.sv
// Top level of the bounded deque with delete by value.
// A command accepted from idle steps through a compare state, then a shift state
// across the cell row with its first-match chain; status, value_out and done are then
// registered. Busy blocks a new command until the previous one leaves the shift state.
// Results cannot be stalled; done is high for one cycle per command.
// Reset empties the deque (count zero, all cells invalid); stored words are not cleared.
`default_nettype none
`include "assert_macros.svh"

module bounded_deque_with_delete #(
    parameter int DEPTH      = bdq_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [bdq_pkg::CMD_W-1:0]      command,
    input  wire logic [bdq_pkg::VALUE_W-1:0]    value,
    output logic                                done,
    output logic [bdq_pkg::STATUS_W-1:0]        status,
    output logic [bdq_pkg::VALUE_W-1:0]         value_out,
    output logic [bdq_pkg::COUNT_W-1:0]         count
);
    import bdq_pkg::*;

    localparam int              CNT_W   = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    fsm_t                  state_reg;
    fsm_t                  state_next;
    cmd_t                  cmd_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  done_reg;
    status_t               status_reg;
    status_t               status_c;
    logic [VALUE_W-1:0]    value_out_reg;
    logic [VALUE_W-1:0]    value_out_c;
    bdq_ctl_t              ctl;
    logic                  accept;

    logic                  valid_w [DEPTH];
    logic [DATA_WIDTH-1:0] data_w  [DEPTH];
    logic                  hit_w   [DEPTH];
    logic [DEPTH-1:0]      valid_vec;

    assign busy   = (state_reg != FSM_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:  state_next = accept ? FSM_MATCH : FSM_IDLE;
            FSM_MATCH: state_next = FSM_EXEC;
            FSM_EXEC:  state_next = FSM_IDLE;
            default:   state_next = FSM_IDLE;
        endcase
    end

    always_comb
    begin
        unique case (cmd_reg) inside
            CMD_PREPEND, CMD_APPEND:
                status_c = (count_reg == DEPTH_C) ? ST_FULL : ST_OK;
            CMD_DEQUEUE:
                status_c = (count_reg == '0) ? ST_EMPTY : ST_OK;
            CMD_DELETE:
                status_c = (count_reg == '0) ? ST_EMPTY :
                           (hit_w[DEPTH-1] ? ST_OK : ST_NOT_FOUND);
            default:
                status_c = ST_OK;
        endcase
    end

    always_comb
    begin
        ctl.compare = (state_reg == FSM_MATCH);
        ctl.apply   = (state_reg == FSM_EXEC) && (status_c == ST_OK);
        ctl.cmd     = cmd_reg;
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.apply)
        begin
            if (cmd_reg == CMD_PREPEND || cmd_reg == CMD_APPEND)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else
            begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    assign value_out_c = (ctl.apply && cmd_reg == CMD_DEQUEUE) ?
                         VALUE_W'(data_w[0]) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= (state_reg == FSM_EXEC);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd_t'(command);
            value_reg <= DATA_WIDTH'(value);
        end
        if (state_reg == FSM_EXEC)
        begin
            status_reg    <= status_c;
            value_out_reg <= value_out_c;
        end
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic                  pv;
            logic [DATA_WIDTH-1:0] pd;
            logic                  ph;
            logic                  nv;
            logic [DATA_WIDTH-1:0] nd;

            if (i == 0)
            begin : g_head
                assign pv = 1'b1;
                assign pd = value_reg;
                assign ph = 1'b0;
            end
            else
            begin : g_body
                assign pv = valid_w[i-1];
                assign pd = data_w[i-1];
                assign ph = hit_w[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                assign nv = 1'b0;
                assign nd = '0;
            end
            else
            begin : g_inner
                assign nv = valid_w[i+1];
                assign nd = data_w[i+1];
            end

            bdq_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .value      (value_reg),
                .prev_valid (pv),
                .prev_data  (pd),
                .prev_hit   (ph),
                .next_valid (nv),
                .next_data  (nd),
                .valid      (valid_w[i]),
                .data       (data_w[i]),
                .hit        (hit_w[i])
            );

            assign valid_vec[i] = valid_w[i];
        end
    endgenerate

    assign done      = done_reg;
    assign status    = status_reg;
    assign value_out = value_out_reg;
    assign count     = COUNT_W'(count_reg);

    `ASSERT_PROP(a_count_bound, clk, rst_n, count_reg <= DEPTH_C)
    `ASSERT_PROP(a_valid_matches_count, clk, rst_n, $countones(valid_vec) == int'(count_reg))
    `ASSERT_IMPL(a_done_after_exec, clk, rst_n, done_reg, $past(state_reg == FSM_EXEC))
    `ASSERT_IMPL(a_count_step, clk, rst_n, state_reg != FSM_EXEC, ##1 $stable(count_reg))

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the bounded deque with delete by value.
`timescale 1ns / 1ps

module testbench;
    import bdq_pkg::*;

    localparam int DEPTH      = 16;
    localparam int RAND_ITEMS = 1600;
    localparam int CALM_TAIL  = 300;

    typedef struct packed {
        status_t     st;
        logic [31:0] word;
        logic [4:0]  cnt;
    } outcome_t;

    typedef struct packed {
        cmd_t        c;
        logic [31:0] v;
        logic        fixed;
        outcome_t    want;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [CMD_W-1:0]    command;
    logic [VALUE_W-1:0]  value;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  value_out;
    logic [COUNT_W-1:0]  count;

    logic [31:0] held_words[$];
    outcome_t    pending_results[$];
    int          failures = 0;

    bounded_deque_with_delete dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .value     (value),
        .done      (done),
        .status    (status),
        .value_out (value_out),
        .count     (count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic outcome_t apply_command(input cmd_t c, input logic [31:0] v);
        outcome_t r;
        int       hit;
        r = '{ST_OK, 32'h0, 5'd0};
        hit = -1;
        case (c)
            CMD_PREPEND:
                if (held_words.size() >= DEPTH) r.st = ST_FULL;
                else held_words.push_front(v);
            CMD_APPEND:
                if (held_words.size() >= DEPTH) r.st = ST_FULL;
                else held_words.push_back(v);
            CMD_DEQUEUE:
                if (held_words.size() == 0) r.st = ST_EMPTY;
                else r.word = held_words.pop_front();
            default:
                if (held_words.size() == 0) r.st = ST_EMPTY;
                else
                begin
                    for (int i = 0; i < held_words.size(); i++)
                        if (hit < 0 && held_words[i] == v) hit = i;
                    if (hit < 0) r.st = ST_NOT_FOUND;
                    else held_words.delete(hit);
                end
        endcase
        r.cnt = 5'(held_words.size());
        return r;
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic transfer_command(input cmd_t c, input logic [31:0] v,
                                    input logic fixed, input outcome_t want);
        outcome_t r;
        start   = 1'b1;
        command = c;
        value   = v;
        do @(posedge clk); while (busy);
        r = apply_command(c, v);
        pending_results.push_back(fixed ? want : r);
        @(negedge clk);
    endtask

    task automatic idle_cycles(input int n);
        start = 1'b0;
        repeat (n) @(negedge clk);
    endtask

    function automatic logic [31:0] pick_word();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4 && held_words.size() > 0)
            return held_words[$urandom_range(0, held_words.size() - 1)];
        if (sel < 6)
            return $urandom_range(0, 7);
        if (sel == 6)
            return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        return $urandom;
    endfunction

    always @(posedge clk)
    begin : check_results
        outcome_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result status %0d value_out %h count %0d",
                         $time, status, value_out, count);
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.st)
                begin
                    $display("%0t: status expected %0d got %0d", $time, want.st, status);
                    failures++;
                end
                if (value_out !== want.word)
                begin
                    $display("%0t: value_out expected %h got %h", $time, want.word, value_out);
                    failures++;
                end
                if (count !== want.cnt)
                begin
                    $display("%0t: count expected %0d got %0d", $time, want.cnt, count);
                    failures++;
                end
            end
        end
    end

    initial
    begin : stimulus
        dir_row_t rows[$];
        outcome_t none;
        int       mode;
        int       mode_left;
        int       pick;
        cmd_t     c;

        none    = '{ST_OK, 32'h0, 5'd0};
        rst_n   = 1'b0;
        start   = 1'b0;
        command = CMD_PREPEND;
        value   = 32'h0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        rows.push_back('{CMD_DEQUEUE, 32'h0,         1'b1, '{ST_EMPTY, 32'h0, 5'd0}});
        rows.push_back('{CMD_DELETE,  32'hFFFF_FFFF, 1'b1, '{ST_EMPTY, 32'h0, 5'd0}});
        rows.push_back('{CMD_APPEND,  32'h0,         1'b1, '{ST_OK, 32'h0, 5'd1}});
        rows.push_back('{CMD_APPEND,  32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'h0, 5'd2}});
        rows.push_back('{CMD_PREPEND, 32'hA5A5_A5A5, 1'b1, '{ST_OK, 32'h0, 5'd3}});
        rows.push_back('{CMD_APPEND,  32'h0,         1'b0, none});
        rows.push_back('{CMD_DELETE,  32'h5A5A_5A5A, 1'b1, '{ST_NOT_FOUND, 32'h0, 5'd4}});
        rows.push_back('{CMD_DELETE,  32'h0,         1'b0, none});
        rows.push_back('{CMD_DEQUEUE, 32'h0,         1'b0, none});
        rows.push_back('{CMD_DELETE,  32'h0,         1'b0, none});
        rows.push_back('{CMD_PREPEND, 32'h1,         1'b0, none});
        for (int i = 0; i < DEPTH - 2; i++)
            rows.push_back('{CMD_APPEND, 32'(i + 2), 1'b0, none});
        rows.push_back('{CMD_APPEND,  32'hFFFF_FFFF, 1'b1, '{ST_FULL, 32'h0, 5'd16}});
        rows.push_back('{CMD_PREPEND, 32'h0,         1'b1, '{ST_FULL, 32'h0, 5'd16}});
        rows.push_back('{CMD_DELETE,  32'(DEPTH - 1), 1'b0, none});
        rows.push_back('{CMD_DEQUEUE, 32'h0,         1'b0, none});

        foreach (rows[i])
        begin
            if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 5));
            transfer_command(rows[i].c, rows[i].v, rows[i].fixed, rows[i].want);
        end

        // let the deque drain its pipeline before the random part
        start = 1'b0;
        wait (pending_results.size() == 0);
        @(negedge clk);

        mode      = 0;
        mode_left = 0;
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 60);
            end
            mode_left--;
            if (n == RAND_ITEMS / 2)
            begin
                start = 1'b0;
                wait (pending_results.size() == 0);
                @(negedge clk);
            end
            if (n < RAND_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0)
                idle_cycles($urandom_range(1, 5));
            pick = $urandom_range(0, 9);
            case (mode)
                0: c = (pick < 7) ? cmd_t'($urandom_range(0, 1)) : cmd_t'($urandom_range(2, 3));
                1: c = (pick < 7) ? cmd_t'($urandom_range(2, 3)) : cmd_t'($urandom_range(0, 1));
                default: c = cmd_t'($urandom_range(0, 3));
            endcase
            transfer_command(c, pick_word(), 1'b0, none);
        end

        start = 1'b0;
        wait (pending_results.size() == 0);
        repeat (10) @(posedge clk);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
